// ===== rtl/core/keyframe_channel_interpolator_assert.svh =====
// ============================================================================
// Assertion macros for the keyframe channel interpolator
// Concurrent checks on clk_i, removed when SYNTH is defined.
// ============================================================================
`ifndef KEYFRAME_CHANNEL_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_CHANNEL_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
`define KCI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kci assertion failed");
`define KCI_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("kci reset assertion failed");
`else
`define KCI_ASSERT(name, prop)
`define KCI_ASSERT_RST(name, prop)
`endif
`endif

// ===== rtl/core/kci_pkg.sv =====
// ============================================================================
// Keyframe channel interpolator package
// Shared types, constants and the saturation function.
// ============================================================================
package kci_pkg;

  localparam int unsigned SBits = 16;
  localparam int unsigned HBits = 20;
  localparam int unsigned AccBits = 68;

  localparam logic [1:0] FuncStep   = 2'd0;
  localparam logic [1:0] FuncLinear = 2'd1;
  localparam logic [1:0] FuncCubic  = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic signed [31:0] ValMax = 32'sh7fffffff;
  localparam logic signed [31:0] ValMin = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] g0;
    logic signed [31:0] g1;
    logic [31:0]        delta;
    logic signed [32:0] diff;
    logic               s_zero;
    logic               s_one;
  } kci_item_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } kci_sat_t;

  function automatic kci_sat_t sat32(input logic signed [AccBits-1:0] x);
    kci_sat_t r;
    r.clip = 1'b0;
    r.val  = x[31:0];
    if (x > AccBits'(ValMax)) begin
      r.clip = 1'b1;
      r.val  = ValMax;
    end else if (x < AccBits'(ValMin)) begin
      r.clip = 1'b1;
      r.val  = ValMin;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/kci_divider.sv =====
// ============================================================================
// Fraction divider
// Pipelined restoring divider, one quotient bit per stage, giving s in Q1.16.
// ============================================================================
module kci_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  kci_pkg::kci_item_t          item_i,
  input  logic [31:0]                 rem_i,
  output logic                        valid_o,
  output kci_pkg::kci_item_t          item_o,
  output logic [kci_pkg::SBits:0]     s_o
);

  localparam int unsigned N = kci_pkg::SBits;

  logic               valid_q [N];
  kci_pkg::kci_item_t item_q  [N];
  logic [31:0]        rem_q   [N];
  logic [N-1:0]       quo_q   [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic               v_in;
    kci_pkg::kci_item_t it_in;
    logic [31:0]        r_in;
    logic [N-1:0]       q_in;
    logic [32:0]        r2;
    logic               ge;
    logic [32:0]        r_sub;

    if (i == 0) begin : g_first
      assign v_in  = valid_i;
      assign it_in = item_i;
      assign r_in  = rem_i;
      assign q_in  = '0;
    end else begin : g_next
      assign v_in  = valid_q[i-1];
      assign it_in = item_q[i-1];
      assign r_in  = rem_q[i-1];
      assign q_in  = quo_q[i-1];
    end

    assign r2    = {r_in, 1'b0};
    assign ge    = r2 >= {1'b0, it_in.delta};
    assign r_sub = r2 - {1'b0, it_in.delta};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[i] <= it_in;
        rem_q[i]  <= ge ? r_sub[31:0] : r2[31:0];
        quo_q[i]  <= {q_in[N-2:0], ge};
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign item_o  = item_q[N-1];

  always_comb begin
    if (item_q[N-1].s_one) begin
      s_o = {1'b1, {N{1'b0}}};
    end else if (item_q[N-1].s_zero) begin
      s_o = '0;
    end else begin
      s_o = {1'b0, quo_q[N-1]};
    end
  end

endmodule

// ===== rtl/core/kci_hermite.sv =====
// ============================================================================
// Interpolation datapath
// Powers of s, scaled tangents, Hermite basis and the weighted sum.
// ============================================================================
module kci_hermite (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  kci_pkg::kci_item_t           item_i,
  input  logic [kci_pkg::SBits:0]      s_i,
  output logic                         valid_o,
  output logic [1:0]                   func_o,
  output logic signed [31:0]           value_o,
  output logic                         saturated_o
);

  localparam int unsigned HB = kci_pkg::HBits;
  localparam int unsigned AB = kci_pkg::AccBits;

  logic [5:0] v_q;

  // Stage 1
  logic [1:0]         f1_q;
  logic signed [31:0] p0_1_q, p1_1_q;
  logic [16:0]        s1_q;
  logic [33:0]        s2p_q;
  logic signed [64:0] pm0_q, pm1_q;
  logic signed [50:0] pl_q;
  // Stage 2
  logic [1:0]         f2_q;
  logic signed [31:0] p0_2_q, p1_2_q;
  logic [16:0]        s_2_q, s2_2_q;
  logic [33:0]        s3p_q;
  logic signed [48:0] m0_2_q, m1_2_q;
  logic signed [35:0] lin_2_q;
  // Stage 3
  logic [1:0]         f3_q;
  logic signed [31:0] p0_3_q, p1_3_q;
  logic signed [48:0] m0_3_q, m1_3_q;
  logic signed [35:0] lin_3_q;
  logic signed [HB-1:0] h00_q, h10_q, h01_q, h11_q;
  // Stage 4
  logic [1:0]         f4_q;
  logic signed [31:0] p0_4_q, p1_4_q;
  logic signed [35:0] lin_4_q;
  logic signed [51:0] a0_q, a1_q;
  logic signed [44:0] m0lo_q, m0hi_q, m1lo_q, m1hi_q;
  // Stage 5
  logic [1:0]         f5_q;
  logic signed [31:0] p0_5_q, p1_5_q;
  logic signed [35:0] lin_5_q;
  logic signed [AB-1:0] t0_q, tm0_q, tm1_q;
  // Stage 6
  logic [1:0]         f6_q;
  logic signed [31:0] p0_6_q, p1_6_q;
  logic signed [35:0] lin_6_q;
  logic signed [AB-1:0] acc_q;

  logic signed [64:0]   pm0_d, pm1_d;
  logic signed [50:0]   pl_d;
  logic signed [35:0]   lin_d;
  logic [16:0]          s3;
  logic signed [HB-1:0] es, es2, es3;
  logic signed [51:0]   a0_d, a1_d;
  logic signed [44:0]   m0lo_d, m0hi_d, m1lo_d, m1hi_d;
  logic signed [AB-1:0] acc_d;
  kci_pkg::kci_sat_t    sat_lin, sat_cub;

  assign pm0_d = item_i.g0 * $signed({1'b0, item_i.delta});
  assign pm1_d = item_i.g1 * $signed({1'b0, item_i.delta});
  assign pl_d  = item_i.diff * $signed({1'b0, s_i});

  assign lin_d = 36'(p0_1_q) + 36'($signed(pl_q[50:16]));

  assign s3  = s3p_q[32:16];
  assign es  = HB'($signed({1'b0, s_2_q}));
  assign es2 = HB'($signed({1'b0, s2_2_q}));
  assign es3 = HB'($signed({1'b0, s3}));

  assign a0_d   = h00_q * p0_3_q;
  assign a1_d   = h01_q * p1_3_q;
  assign m0lo_d = h10_q * $signed({1'b0, m0_3_q[23:0]});
  assign m0hi_d = h10_q * $signed(m0_3_q[48:24]);
  assign m1lo_d = h11_q * $signed({1'b0, m1_3_q[23:0]});
  assign m1hi_d = h11_q * $signed(m1_3_q[48:24]);

  assign acc_d = t0_q + tm0_q + tm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q   <= item_i.func;
      p0_1_q <= item_i.p0;
      p1_1_q <= item_i.p1;
      s1_q   <= s_i;
      s2p_q  <= s_i * s_i;
      pm0_q  <= pm0_d;
      pm1_q  <= pm1_d;
      pl_q   <= pl_d;

      f2_q    <= f1_q;
      p0_2_q  <= p0_1_q;
      p1_2_q  <= p1_1_q;
      s_2_q   <= s1_q;
      s2_2_q  <= s2p_q[32:16];
      s3p_q   <= s2p_q[32:16] * s1_q;
      m0_2_q  <= pm0_q[64:16];
      m1_2_q  <= pm1_q[64:16];
      lin_2_q <= lin_d;

      f3_q    <= f2_q;
      p0_3_q  <= p0_2_q;
      p1_3_q  <= p1_2_q;
      m0_3_q  <= m0_2_q;
      m1_3_q  <= m1_2_q;
      lin_3_q <= lin_2_q;
      h00_q   <= (es3 <<< 1) - (es2 + (es2 <<< 1)) + HB'(65536);
      h10_q   <= es3 - (es2 <<< 1) + es;
      h01_q   <= (es2 + (es2 <<< 1)) - (es3 <<< 1);
      h11_q   <= es3 - es2;

      f4_q    <= f3_q;
      p0_4_q  <= p0_3_q;
      p1_4_q  <= p1_3_q;
      lin_4_q <= lin_3_q;
      a0_q    <= a0_d;
      a1_q    <= a1_d;
      m0lo_q  <= m0lo_d;
      m0hi_q  <= m0hi_d;
      m1lo_q  <= m1lo_d;
      m1hi_q  <= m1hi_d;

      f5_q    <= f4_q;
      p0_5_q  <= p0_4_q;
      p1_5_q  <= p1_4_q;
      lin_5_q <= lin_4_q;
      t0_q    <= AB'(a0_q) + AB'(a1_q);
      tm0_q   <= (AB'(m0hi_q) <<< 24) + AB'(m0lo_q);
      tm1_q   <= (AB'(m1hi_q) <<< 24) + AB'(m1lo_q);

      f6_q    <= f5_q;
      p0_6_q  <= p0_5_q;
      p1_6_q  <= p1_5_q;
      lin_6_q <= lin_5_q;
      acc_q   <= acc_d;
    end
  end

  assign sat_lin = kci_pkg::sat32(AB'(lin_6_q));
  assign sat_cub = kci_pkg::sat32(acc_q >>> 16);

  assign valid_o = v_q[5];
  assign func_o  = f6_q;

  always_comb begin
    case (f6_q)
      kci_pkg::FuncStep: begin
        value_o     = p0_6_q;
        saturated_o = 1'b0;
      end
      kci_pkg::FuncLinear: begin
        value_o     = sat_lin.val;
        saturated_o = sat_lin.clip;
      end
      kci_pkg::FuncCubic: begin
        value_o     = sat_cub.val;
        saturated_o = sat_cub.clip;
      end
      default: begin
        value_o     = p1_6_q;
        saturated_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/keyframe_channel_interpolator.sv =====
// Throughput: one word per cycle; the 16-stage divider and the multiplier
// stages are fully pipelined and advance together whenever the output is free.
// Reset: rst_ni clears all valid bits asynchronously; data registers keep
// their contents.
// ============================================================================
// Keyframe channel interpolator
// Step, linear and cubic Hermite interpolation of one channel component; func code 3 passes the next keyframe value.
// ============================================================================
`include "keyframe_channel_interpolator_assert.svh"

module keyframe_channel_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        sample_time_i,
  input  logic [31:0]        prev_time_i,
  input  logic [31:0]        next_time_i,
  input  logic signed [31:0] prev_value_i,
  input  logic signed [31:0] next_value_i,
  input  logic signed [31:0] prev_out_tangent_i,
  input  logic signed [31:0] next_in_tangent_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);

  logic               en;
  logic               in_valid_q;
  logic [1:0]         func_q;
  logic [31:0]        t_q, t0_q, t1_q;
  logic signed [31:0] p0_q, p1_q, g0_q, g1_q;

  logic               it_valid_q;
  kci_pkg::kci_item_t item_d, item_q;
  logic [31:0]        rem_d, rem_q;
  logic [31:0]        num;

  logic                    div_valid;
  kci_pkg::kci_item_t      div_item;
  logic [kci_pkg::SBits:0] div_s;

  logic               h_valid;
  logic [1:0]         h_func;
  logic signed [31:0] h_value;
  logic               h_sat;

  logic               out_valid_q;
  logic [1:0]         out_func_q;
  logic signed [31:0] out_value_q;
  logic               out_sat_q;

  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  always_comb begin
    item_d.func  = func_q;
    item_d.p0    = p0_q;
    item_d.p1    = p1_q;
    item_d.g0    = g0_q;
    item_d.g1    = g1_q;
    item_d.delta = (t1_q > t0_q) ? (t1_q - t0_q) : '0;
    item_d.diff  = 33'(p1_q) - 33'(p0_q);
    num          = t_q - t0_q;
    item_d.s_zero = (item_d.delta == '0) || (t_q <= t0_q);
    item_d.s_one  = !item_d.s_zero && (num >= item_d.delta);
    rem_d         = num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      it_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q  <= valid_i;
      it_valid_q  <= in_valid_q;
      out_valid_q <= h_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_q      <= func_i;
      t_q         <= sample_time_i;
      t0_q        <= prev_time_i;
      t1_q        <= next_time_i;
      p0_q        <= prev_value_i;
      p1_q        <= next_value_i;
      g0_q        <= prev_out_tangent_i;
      g1_q        <= next_in_tangent_i;
      item_q      <= item_d;
      rem_q       <= rem_d;
      out_func_q  <= h_func;
      out_value_q <= h_value;
      out_sat_q   <= h_sat;
    end
  end

  kci_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (it_valid_q),
    .item_i  (item_q),
    .rem_i   (rem_q),
    .valid_o (div_valid),
    .item_o  (div_item),
    .s_o     (div_s)
  );

  kci_hermite u_herm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (div_valid),
    .item_i      (div_item),
    .s_i         (div_s),
    .valid_o     (h_valid),
    .func_o      (h_func),
    .value_o     (h_value),
    .saturated_o (h_sat)
  );

  assign valid_o     = out_valid_q;
  assign value_o     = out_value_q;
  assign saturated_o = out_sat_q;

  `KCI_ASSERT(a_sat_extreme, out_valid_q && out_sat_q |-> (out_value_q == kci_pkg::ValMax) || (out_value_q == kci_pkg::ValMin))
  `KCI_ASSERT(a_step_no_sat, out_valid_q && (out_func_q == kci_pkg::FuncStep) |-> !out_sat_q)
  `KCI_ASSERT(a_hold_front, stall_o |=> $stable(in_valid_q) && $stable(it_valid_q))
  `KCI_ASSERT_RST(a_reset_idle, !rst_ni |=> !valid_o)

endmodule
